// ===== hdl/xoshiro_pkg.sv =====
// Shared types, constants and functions for the xoshiro256** generator with jump unit.
package xoshiro_pkg;

   // Four 64-bit generator words, word 0 in the low slot.
   typedef logic [3:0][63:0] gen_state_type;

   // Operation codes carried on req_operation.
   typedef enum logic [2:0] {
      OP_NEXT64    = 3'd0,
      OP_NEXT32    = 3'd1,
      OP_RANGE     = 3'd2,
      OP_JUMP      = 3'd3,
      OP_FAR_JUMP  = 3'd4,
      OP_RESEED    = 3'd5
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_LOAD,
      ST_SEED,
      ST_SEED_DONE,
      ST_DIV,
      ST_RANGE_OUT,
      ST_JUMP,
      ST_JUMP_DONE
   } ctrl_state_type;

   // Datapath commands issued by the controller.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_DRAW64,
      CMD_DRAW32,
      CMD_RESP_ZERO,
      CMD_RANGE_EMPTY,
      CMD_RANGE_FULL,
      CMD_RANGE_DRAW,
      CMD_DIV_STEP,
      CMD_RANGE_DONE,
      CMD_JUMP_START,
      CMD_JUMP_STEP,
      CMD_JUMP_DONE,
      CMD_SEED_LOAD,
      CMD_SEED_DEFAULT,
      CMD_MIX_ADD,
      CMD_MUL_LL,
      CMD_MUL_HL,
      CMD_MUL_LH,
      CMD_MIX_SHIFT,
      CMD_STORE_WORD
   } dp_cmd_type;

   // Command bundle from controller to datapath.
   typedef struct packed {
      dp_cmd_type  code;
      logic [1:0]  word_idx;
      logic        mul_sel;
      logic [7:0]  step;
      logic        far_jump;
   } dp_cmd_struct_type;

   // Status bundle from datapath to controller.
   typedef struct packed {
      logic range_empty;
      logic span_zero;
   } dp_status_type;

   // Seeding constants.
   localparam logic [63:0] DEFAULT_SEED = 64'h106689d45497fdb5;
   localparam logic [63:0] SM_GOLDEN    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL1      = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL2      = 64'h94d049bb133111eb;

   // Jump polynomials, word 0 last in each list.
   localparam logic [3:0][63:0] JUMP_POLY = {
      64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
      64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
   };
   localparam logic [3:0][63:0] FAR_JUMP_POLY = {
      64'h39109bb02acbe635, 64'h77710069854ee241,
      64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
   };

   // One xoshiro256 state transition.
   function automatic gen_state_type xo_advance(input gen_state_type s);
      gen_state_type n;
      logic [63:0]   t;
      t    = s[1] << 17;
      n    = s;
      n[2] = n[2] ^ n[0];
      n[3] = n[3] ^ n[1];
      n[1] = n[1] ^ n[2];
      n[0] = n[0] ^ n[3];
      n[2] = n[2] ^ t;
      n[3] = (n[3] << 45) | (n[3] >> 19);
      return n;
   endfunction

   // Star-star scrambler: rotl(s1 * 5, 7) * 9, multiplies as shift-adds.
   function automatic logic [63:0] xo_scramble(input logic [63:0] s1);
      logic [63:0] m5;
      logic [63:0] r;
      m5 = s1 + (s1 << 2);
      r  = (m5 << 7) | (m5 >> 57);
      return r + (r << 3);
   endfunction

endpackage

// ===== hdl/xoshiro256ss_generator_with_jump_unit.sv =====
// Next64, next32, unused codes, empty and full-span ranges: result in the cycle after transfer, one transfer per cycle.
// Other range draws: the bit-serial remainder unit runs in ST_DIV, then ST_RANGE_OUT registers the result.
// Jump and long jump: one polynomial bit per cycle in ST_JUMP, then ST_JUMP_DONE loads the accumulated words.
// Reseed: the splitmix64 sequence runs on the shared 32x32 multiplier in ST_SEED, then ST_SEED_DONE responds.
// After reset busy stays high while the default seed is expanded.
// Results are presented for one cycle on rsp_strobe; the receiver cannot stall.
module xoshiro256ss_generator_with_jump_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [63:0]        req_seed,
   input  logic signed [31:0] req_range_low,
   input  logic signed [31:0] req_range_high,
   output logic               rsp_strobe,
   output logic [63:0]        rsp_value,
   output logic signed [31:0] rsp_range_value
);
   import xoshiro_pkg::*;

   dp_cmd_struct_type cmd;
   dp_status_type     status;

   // Sequencer.
   xoshiro_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   // Generator datapath.
   xoshiro_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_seed        (req_seed),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value),
      .rsp_range_value (rsp_range_value)
   );

endmodule

// ===== hdl/xoshiro_ctrl.sv =====
// Controller state machine that sequences the generator datapath.
module xoshiro_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2:0]                    req_operation,
   input  xoshiro_pkg::dp_status_type    status,
   output logic                          busy,
   output xoshiro_pkg::dp_cmd_struct_type cmd
);
   import xoshiro_pkg::*;

   // Steps of one splitmix64 draw.
   localparam logic [3:0] PH_ADD      = 4'd0;
   localparam logic [3:0] PH_M1_LL    = 4'd1;
   localparam logic [3:0] PH_M1_HL    = 4'd2;
   localparam logic [3:0] PH_M1_LH    = 4'd3;
   localparam logic [3:0] PH_SHIFT    = 4'd4;
   localparam logic [3:0] PH_M2_LL    = 4'd5;
   localparam logic [3:0] PH_M2_HL    = 4'd6;
   localparam logic [3:0] PH_M2_LH    = 4'd7;
   localparam logic [3:0] PH_STORE    = 4'd8;
   localparam logic [7:0] DIV_LAST    = 8'd31;
   localparam logic [7:0] JUMP_LAST   = 8'd255;
   localparam logic [1:0] WORD_LAST   = 2'd3;

   ctrl_state_type state_ff, state_in;
   logic [3:0]     phase_ff, phase_in;
   logic [1:0]     word_ff, word_in;
   logic [7:0]     step_ff, step_in;
   logic           long_ff, long_in;
   logic           init_ff, init_in;
   logic           seed_last;
   logic           accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign seed_last = (phase_ff == PH_STORE) && (word_ff == WORD_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_RANGE: begin
                     if (!status.range_empty && !status.span_zero) state_in = ST_DIV;
                  end
                  OP_JUMP, OP_FAR_JUMP: state_in = ST_JUMP;
                  OP_RESEED:            state_in = ST_SEED;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT_LOAD: state_in = ST_SEED;
         ST_SEED: begin
            if (seed_last) state_in = init_ff ? ST_IDLE : ST_SEED_DONE;
         end
         ST_SEED_DONE: state_in = ST_IDLE;
         ST_DIV: begin
            if (step_ff == DIV_LAST) state_in = ST_RANGE_OUT;
         end
         ST_RANGE_OUT: state_in = ST_IDLE;
         ST_JUMP: begin
            if (step_ff == JUMP_LAST) state_in = ST_JUMP_DONE;
         end
         ST_JUMP_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Counters and flags.
   always_comb begin
      phase_in = 4'd0;
      word_in  = 2'd0;
      step_in  = 8'd0;
      long_in  = long_ff;
      init_in  = init_ff;
      if (accept) long_in = (req_operation == OP_FAR_JUMP);
      if (state_ff == ST_SEED) begin
         if (phase_ff == PH_STORE) begin
            word_in = word_ff + 2'd1;
         end else begin
            phase_in = phase_ff + 4'd1;
            word_in  = word_ff;
         end
         if (seed_last) init_in = 1'b0;
      end
      if ((state_ff == ST_DIV) || (state_ff == ST_JUMP)) step_in = step_ff + 8'd1;
   end

   // Outputs: busy and datapath command.
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      cmd.code      = CMD_NONE;
      cmd.word_idx  = word_ff;
      cmd.mul_sel   = 1'b0;
      cmd.step      = step_ff;
      cmd.far_jump  = long_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_operation)
                  OP_NEXT64: cmd.code = CMD_DRAW64;
                  OP_NEXT32: cmd.code = CMD_DRAW32;
                  OP_RANGE: begin
                     if (status.range_empty)     cmd.code = CMD_RANGE_EMPTY;
                     else if (status.span_zero)  cmd.code = CMD_RANGE_FULL;
                     else                        cmd.code = CMD_RANGE_DRAW;
                  end
                  OP_JUMP, OP_FAR_JUMP: cmd.code = CMD_JUMP_START;
                  OP_RESEED:            cmd.code = CMD_SEED_LOAD;
                  default:              cmd.code = CMD_RESP_ZERO;
               endcase
            end
         end
         ST_INIT_LOAD: cmd.code = CMD_SEED_DEFAULT;
         ST_SEED: begin
            cmd.mul_sel = (phase_ff > PH_SHIFT);
            case (phase_ff)
               PH_ADD:             cmd.code = CMD_MIX_ADD;
               PH_M1_LL, PH_M2_LL: cmd.code = CMD_MUL_LL;
               PH_M1_HL, PH_M2_HL: cmd.code = CMD_MUL_HL;
               PH_M1_LH, PH_M2_LH: cmd.code = CMD_MUL_LH;
               PH_SHIFT:           cmd.code = CMD_MIX_SHIFT;
               PH_STORE:           cmd.code = CMD_STORE_WORD;
               default:            cmd.code = CMD_NONE;
            endcase
         end
         ST_SEED_DONE: cmd.code = CMD_RESP_ZERO;
         ST_DIV:       cmd.code = CMD_DIV_STEP;
         ST_RANGE_OUT: cmd.code = CMD_RANGE_DONE;
         ST_JUMP:      cmd.code = CMD_JUMP_STEP;
         ST_JUMP_DONE: cmd.code = CMD_JUMP_DONE;
         default:      cmd.code = CMD_NONE;
      endcase
   end

   // State registers; reset starts the default seeding pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_LOAD;
         phase_ff <= 4'd0;
         word_ff  <= 2'd0;
         step_ff  <= 8'd0;
         long_ff  <= 1'b0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         word_ff  <= word_in;
         step_ff  <= step_in;
         long_ff  <= long_in;
         init_ff  <= init_in;
      end
   end

endmodule

// ===== hdl/xoshiro_dp.sv =====
// Datapath: generator words, splitmix64 seeder, jump accumulator and range divider.
module xoshiro_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  xoshiro_pkg::dp_cmd_struct_type cmd,
   input  logic [63:0]                    req_seed,
   input  logic signed [31:0]             req_range_low,
   input  logic signed [31:0]             req_range_high,
   output xoshiro_pkg::dp_status_type     status,
   output logic                           rsp_strobe,
   output logic [63:0]                    rsp_value,
   output logic signed [31:0]             rsp_range_value
);
   import xoshiro_pkg::*;

   gen_state_type      words_ff, words_in;
   gen_state_type      acc_ff, acc_in;
   gen_state_type      adv;
   logic [63:0]        draw;
   logic [31:0]        draw_hi;
   logic [63:0]        x_ff, x_in, x_sum;
   logic [63:0]        z_ff, z_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        mul_const;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        span_ff, span_in;
   logic [31:0]        span_req;
   logic [31:0]        quot_ff, quot_in;
   logic [31:0]        rem_ff, rem_in;
   logic [32:0]        rem_sh;
   logic [32:0]        rem_diff;
   logic [3:0][63:0]   poly;
   logic               poly_bit;
   logic               strobe_ff, strobe_in;
   logic [63:0]        value_ff, value_in;
   logic [31:0]        range_ff, range_in;

   // Draw and advance of the current words.
   assign adv     = xo_advance(words_ff);
   assign draw    = xo_scramble(words_ff[1]);
   assign draw_hi = draw[63:32];

   // Range decode seen by the controller.
   assign span_req           = req_range_high - req_range_low + 32'd1;
   assign status.range_empty = (req_range_high <= req_range_low);
   assign status.span_zero   = (span_req == 32'd0);

   // Shared 32x32 multiplier for the splitmix64 constant products.
   assign mul_const = cmd.mul_sel ? SM_MUL2 : SM_MUL1;
   always_comb begin
      mul_a = z_ff[31:0];
      mul_b = mul_const[31:0];
      case (cmd.code)
         CMD_MUL_HL: mul_a = z_ff[63:32];
         CMD_MUL_LH: mul_b = mul_const[63:32];
         default: begin
            mul_a = z_ff[31:0];
            mul_b = mul_const[31:0];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Splitmix64 pre-add and remainder step.
   assign x_sum    = x_ff + SM_GOLDEN;
   assign rem_sh   = {rem_ff, quot_ff[31]};
   assign rem_diff = rem_sh - {1'b0, span_ff};

   // Jump polynomial bit for this step.
   assign poly     = cmd.far_jump ? FAR_JUMP_POLY : JUMP_POLY;
   assign poly_bit = poly[cmd.step[7:6]][cmd.step[5:0]];

   // Next values of every datapath register.
   always_comb begin
      words_in  = words_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      z_in      = z_ff;
      prod_in   = prod_ff;
      lo_in     = lo_ff;
      span_in   = span_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      strobe_in = 1'b0;
      value_in  = 64'd0;
      range_in  = 32'd0;
      case (cmd.code)
         CMD_DRAW64: begin
            words_in  = adv;
            value_in  = draw;
            strobe_in = 1'b1;
         end
         CMD_DRAW32: begin
            words_in  = adv;
            value_in  = {32'd0, draw_hi};
            strobe_in = 1'b1;
         end
         CMD_RESP_ZERO: strobe_in = 1'b1;
         CMD_RANGE_EMPTY: begin
            range_in  = req_range_low;
            strobe_in = 1'b1;
         end
         CMD_RANGE_FULL: begin
            words_in  = adv;
            range_in  = req_range_low + draw_hi;
            strobe_in = 1'b1;
         end
         CMD_RANGE_DRAW: begin
            words_in = adv;
            lo_in    = req_range_low;
            span_in  = span_req;
            quot_in  = draw_hi;
            rem_in   = 32'd0;
         end
         CMD_DIV_STEP: begin
            quot_in = {quot_ff[30:0], 1'b0};
            rem_in  = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
         end
         CMD_RANGE_DONE: begin
            range_in  = lo_ff + rem_ff;
            strobe_in = 1'b1;
         end
         CMD_JUMP_START: acc_in = '0;
         CMD_JUMP_STEP: begin
            if (poly_bit) begin
               acc_in = acc_ff ^ words_ff;
            end
            words_in = adv;
         end
         CMD_JUMP_DONE: begin
            words_in  = acc_ff;
            value_in  = acc_ff[0] ^ acc_ff[1] ^ acc_ff[2] ^ acc_ff[3];
            strobe_in = 1'b1;
         end
         CMD_SEED_LOAD:    x_in = (req_seed == 64'd0) ? DEFAULT_SEED : req_seed;
         CMD_SEED_DEFAULT: x_in = DEFAULT_SEED;
         CMD_MIX_ADD: begin
            x_in = x_sum;
            z_in = x_sum ^ (x_sum >> 30);
         end
         CMD_MUL_LL: prod_in = mul_p;
         CMD_MUL_HL, CMD_MUL_LH: prod_in = prod_ff + {mul_p[31:0], 32'd0};
         CMD_MIX_SHIFT: z_in = prod_ff ^ (prod_ff >> 27);
         CMD_STORE_WORD: words_in[cmd.word_idx] = prod_ff ^ (prod_ff >> 31);
         default: strobe_in = 1'b0;
      endcase
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      words_ff <= words_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      z_ff     <= z_in;
      prod_ff  <= prod_in;
      lo_ff    <= lo_in;
      span_ff  <= span_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      value_ff <= value_in;
      range_ff <= range_in;
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_value       = value_ff;
   assign rsp_range_value = range_ff;

endmodule
